FILE: rtl/core/sfa_pkg.sv
// Shared types, opcodes and constants of the specific force accelerometer.
// No dependencies; used by sfa_ctrl, sfa_datapath and the top level.
package sfa_pkg;

    // datapath operations
    localparam logic [2:0] OP_CORDIC   = 3'd0;
    localparam logic [2:0] OP_ROT      = 3'd1;
    localparam logic [2:0] OP_DIV_MASS = 3'd2;
    localparam logic [2:0] OP_DIV_VEL  = 3'd3;
    localparam logic [2:0] OP_AVG      = 3'd4;

    // step sequence: last step of a priming item and last step overall
    localparam logic [4:0] SEQ_PRIME_END = 5'd8;
    localparam logic [4:0] SEQ_LAST      = 5'd15;

    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [33:0] GAIN_INV    = 34'sd652032874;

    typedef struct packed {
        logic signed [31:0] angle_x;
        logic signed [31:0] angle_y;
        logic signed [31:0] angle_z;
        logic signed [47:0] weight_x;
        logic signed [47:0] weight_y;
        logic signed [47:0] weight_z;
        logic        [47:0] body_mass;
        logic signed [47:0] vel_x;
        logic signed [47:0] vel_y;
        logic signed [47:0] vel_z;
        logic        [31:0] step_time;
    } t_in;

    typedef struct packed {
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
        logic               updated;
    } t_out;

    typedef struct packed {
        logic       load;
        logic       start;
        logic       finish;
        logic [2:0] op;
        logic [2:0] sel;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic primed;
        logic out_busy;
    } t_sts;

    // arctangent of 2^-k, Q2.30, truncated
    function automatic logic [30:0] atan_q30(input logic [4:0] k);
        logic [30:0] v;
        case (k)
            5'd0:  v = 31'h3243F6A8;
            5'd1:  v = 31'h1DAC6705;
            5'd2:  v = 31'h0FADBAFC;
            5'd3:  v = 31'h07F56EA6;
            5'd4:  v = 31'h03FEAB76;
            5'd5:  v = 31'h01FFD55B;
            5'd6:  v = 31'h00FFFAAA;
            5'd7:  v = 31'h007FFF55;
            5'd8:  v = 31'h003FFFEA;
            5'd9:  v = 31'h001FFFFD;
            5'd10: v = 31'h000FFFFF;
            5'd11: v = 31'h0007FFFF;
            5'd12: v = 31'h0003FFFF;
            5'd13: v = 31'h0001FFFF;
            5'd14: v = 31'h0000FFFF;
            5'd15: v = 31'h00007FFF;
            5'd16: v = 31'h00003FFF;
            5'd17: v = 31'h00001FFF;
            5'd18: v = 31'h00000FFF;
            5'd19: v = 31'h000007FF;
            5'd20: v = 31'h000003FF;
            5'd21: v = 31'h000001FF;
            5'd22: v = 31'h000000FF;
            5'd23: v = 31'h0000007F;
            5'd24: v = 31'h0000003F;
            5'd25: v = 31'h0000001F;
            5'd26: v = 31'h0000000F;
            5'd27: v = 31'h00000007;
            5'd28: v = 31'h00000003;
            5'd29: v = 31'h00000001;
            default: v = 31'h0;
        endcase
        return v;
    endfunction

    // operation and selector of each step: {op, sel}
    function automatic logic [5:0] seq_cmd(input logic [4:0] step);
        logic [5:0] v;
        case (step)
            5'd0:  v = {OP_CORDIC, 3'd0};
            5'd1:  v = {OP_CORDIC, 3'd1};
            5'd2:  v = {OP_CORDIC, 3'd2};
            5'd3:  v = {OP_ROT, 3'd0};
            5'd4:  v = {OP_ROT, 3'd1};
            5'd5:  v = {OP_ROT, 3'd2};
            5'd6:  v = {OP_DIV_MASS, 3'd0};
            5'd7:  v = {OP_DIV_MASS, 3'd1};
            5'd8:  v = {OP_DIV_MASS, 3'd2};
            5'd9:  v = {OP_DIV_VEL, 3'd0};
            5'd10: v = {OP_DIV_VEL, 3'd1};
            5'd11: v = {OP_DIV_VEL, 3'd2};
            5'd12: v = {OP_AVG, 3'd0};
            5'd13: v = {OP_ROT, 3'd3};
            5'd14: v = {OP_ROT, 3'd4};
            5'd15: v = {OP_ROT, 3'd5};
            default: v = {OP_AVG, 3'd0};
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/core/sfa_ctrl.sv
// Sequencer of the specific force accelerometer: walks the step list and
// drives datapath commands. Depends on sfa_pkg.
module sfa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  sfa_pkg::t_sts i_sts,
    output logic          o_in_stall,
    output sfa_pkg::t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic [1:0] r_state, n_state;
    logic [4:0] r_step, n_step;
    logic [5:0] step_cmd;

    assign step_cmd = sfa_pkg::seq_cmd(r_step);

    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        o_cmd        = '0;
        o_cmd.op     = step_cmd[5:3];
        o_cmd.sel    = step_cmd[2:0];
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = S_ISSUE;
                end
            end
            S_ISSUE: begin
                o_cmd.start = 1'b1;
                n_state     = S_WAIT;
            end
            S_WAIT: begin
                if (i_sts.done) begin
                    // a priming item stops after the mass divisions
                    if (r_step == sfa_pkg::SEQ_LAST ||
                        (r_step == sfa_pkg::SEQ_PRIME_END && !i_sts.primed)) begin
                        n_state = S_FIN;
                    end else begin
                        n_step  = r_step + 5'd1;
                        n_state = S_ISSUE;
                    end
                end
            end
            S_FIN: begin
                if (!i_sts.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

FILE: rtl/core/sfa_datapath.sv
// Datapath of the specific force accelerometer: CORDIC, multiply-accumulate
// rotator, bit-serial divider, averaging and held state. Depends on sfa_pkg.
module sfa_datapath #(
    parameter int VALUE_WIDTH  = 48,
    parameter int CORDIC_STEPS = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sfa_pkg::t_cmd i_cmd,
    input  sfa_pkg::t_in  i_in_data,
    input  logic          i_out_stall,
    output sfa_pkg::t_sts o_sts,
    output logic          o_out_valid,
    output sfa_pkg::t_out o_out_data
);

    localparam int VW = VALUE_WIDTH;
    localparam int NW = (VW + 16 > 73) ? VW + 16 : 73;
    localparam int CW = $clog2(NW + 2);
    localparam logic [CW-1:0] CORDIC_END = CW'(CORDIC_STEPS + 1);
    localparam logic [CW-1:0] ROT_END    = CW'(11);
    localparam logic [CW-1:0] DIV_END    = CW'(NW + 1);

    function automatic logic signed [VW-1:0] sat_vw(input logic signed [97:0] v);
        logic signed [97:0] maxv;
        logic signed [97:0] minv;
        maxv = (98'sd1 <<< (VW - 1)) - 98'sd1;
        minv = -maxv - 98'sd1;
        if (v > maxv)
            return maxv[VW-1:0];
        else if (v < minv)
            return minv[VW-1:0];
        return v[VW-1:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [97:0] v);
        if (v > 98'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -98'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    sfa_pkg::t_in r_in;
    sfa_pkg::t_out r_out;
    logic r_out_valid;
    logic r_act;
    logic [2:0] r_op, r_sel;
    logic [CW-1:0] r_cnt;

    logic signed [VW-1:0] r_f [3];
    logic signed [VW-1:0] r_a [3];
    logic signed [VW-1:0] r_lf [3];
    logic signed [47:0] r_lv [3];
    logic [31:0] r_lstep;
    logic signed [31:0] r_cos [3];
    logic signed [31:0] r_sin [3];
    logic r_primed;
    logic signed [31:0] r_held [2];

    // CORDIC
    logic signed [33:0] r_cx, r_cy, r_cz;
    logic r_flip;
    // rotator
    logic signed [VW-1:0] r_p, r_q, r_np;
    logic signed [31:0] r_c, r_s;
    logic signed [64:0] r_prod;
    logic r_prod_hi, r_prod_neg, r_prod_first;
    logic signed [97:0] r_acc;
    // divider
    logic [NW-1:0] r_num;
    logic [47:0] r_rem, r_dd;
    logic r_neg;

    logic [CW-1:0] op_end;
    logic done;
    logic [1:0] sidx;

    assign sidx = r_sel[1:0];

    always_comb begin
        case (r_op)
            sfa_pkg::OP_CORDIC:   op_end = CORDIC_END;
            sfa_pkg::OP_ROT:      op_end = ROT_END;
            sfa_pkg::OP_DIV_MASS: op_end = DIV_END;
            sfa_pkg::OP_DIV_VEL:  op_end = DIV_END;
            default:              op_end = '0;
        endcase
    end

    assign done = r_act && (r_cnt == op_end);

    // rotation map: operand pair, angle, bank and sine sign
    logic [1:0] rot_p, rot_q, rot_ax;
    logic rot_bank, rot_neg;
    always_comb begin
        rot_bank = (r_sel >= 3'd3);
        rot_neg  = (r_sel < 3'd3);
        case (r_sel)
            3'd0:    begin rot_p = 2'd0; rot_q = 2'd1; rot_ax = 2'd2; end
            3'd1:    begin rot_p = 2'd2; rot_q = 2'd0; rot_ax = 2'd1; end
            3'd2:    begin rot_p = 2'd1; rot_q = 2'd2; rot_ax = 2'd0; end
            3'd3:    begin rot_p = 2'd1; rot_q = 2'd2; rot_ax = 2'd0; end
            3'd4:    begin rot_p = 2'd2; rot_q = 2'd0; rot_ax = 2'd1; end
            default: begin rot_p = 2'd0; rot_q = 2'd1; rot_ax = 2'd2; end
        endcase
    end

    logic signed [31:0] ang_sel;
    logic signed [47:0] vel_sel;
    always_comb begin
        case (sidx)
            2'd0:    begin ang_sel = r_in.angle_x; vel_sel = r_in.vel_x; end
            2'd1:    begin ang_sel = r_in.angle_y; vel_sel = r_in.vel_y; end
            default: begin ang_sel = r_in.angle_z; vel_sel = r_in.vel_z; end
        endcase
    end

    // CORDIC iteration and start values
    logic [CW-1:0] cnt_m1;
    logic [4:0] k;
    logic signed [33:0] atanv, dx, dy, z0, cos_n, sin_n;
    logic signed [33:0] n_cx, n_cy, n_cz, n_z0;
    logic n_flip0;
    always_comb begin
        cnt_m1 = r_cnt - CW'(1);
        k      = cnt_m1[4:0];
        atanv  = $signed(34'(sfa_pkg::atan_q30(k)));
        dx     = r_cy >>> k;
        dy     = r_cx >>> k;
        if (r_cz >= 0) begin
            n_cx = r_cx - dx;
            n_cy = r_cy + dy;
            n_cz = r_cz - atanv;
        end else begin
            n_cx = r_cx + dx;
            n_cy = r_cy - dy;
            n_cz = r_cz + atanv;
        end
        z0 = 34'(ang_sel) <<< 1;
        n_flip0 = 1'b0;
        n_z0    = z0;
        if (z0 > sfa_pkg::HALF_PI_Q30) begin
            n_z0    = z0 - sfa_pkg::PI_Q30;
            n_flip0 = 1'b1;
        end else if (z0 < -sfa_pkg::HALF_PI_Q30) begin
            n_z0    = z0 + sfa_pkg::PI_Q30;
            n_flip0 = 1'b1;
        end
        cos_n = r_flip ? -r_cx : r_cx;
        sin_n = r_flip ? -r_cy : r_cy;
    end

    // rotator partial products: j = {pair, term, half}
    logic [2:0] j;
    logic signed [31:0] coef;
    logic signed [VW-1:0] vec;
    logic signed [63:0] v64;
    logic signed [32:0] chunk;
    logic signed [97:0] term, rnd, rnd_q;
    always_comb begin
        j     = r_cnt[2:0] - 3'd2;
        coef  = (j[2] ^ j[1]) ? r_s : r_c;
        vec   = j[1] ? r_q : r_p;
        v64   = 64'(vec);
        // upper half carries the sign, lower half is unsigned
        chunk = j[0] ? 33'($signed(v64[63:32])) : $signed({1'b0, v64[31:0]});
        term  = 98'(r_prod);
        if (r_prod_hi)
            term = term <<< 32;
        if (r_prod_neg)
            term = -term;
        rnd   = (r_acc + 98'sd536870912) >>> 30;
        rnd_q = rnd;
    end

    // divider step and result
    logic signed [97:0] num98, mag98, q98, sq98;
    logic [48:0] trial;
    logic ge;
    logic signed [VW-1:0] div_res;
    always_comb begin
        if (r_op == sfa_pkg::OP_DIV_MASS)
            num98 = 98'(r_f[sidx]) <<< 16;
        else
            num98 = (98'(vel_sel) - 98'(r_lv[sidx])) <<< 24;
        mag98 = num98[97] ? -num98 : num98;
        trial = {r_rem, r_num[NW-1]};
        ge    = trial >= {1'b0, r_dd};
        q98   = $signed(98'(r_num));
        sq98  = r_neg ? -q98 : q98;
        div_res = (r_dd == '0) ? '0 : sat_vw(sq98);
    end

    logic signed [31:0] n_held0, n_held1;
    assign n_held0 = r_primed ? sat32(-98'(r_a[2])) : r_held[0];
    assign n_held1 = r_primed ? sat32(-98'(r_a[1])) : r_held[1];

    // control and kept state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act       <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_primed    <= 1'b0;
            r_held[0]   <= '0;
            r_held[1]   <= '0;
            r_lstep     <= '0;
            for (int i = 0; i < 3; i++) begin
                r_lf[i] <= '0;
                r_lv[i] <= '0;
            end
        end else begin
            if (i_cmd.start) begin
                r_act <= 1'b1;
                r_cnt <= '0;
            end else if (done) begin
                r_act <= 1'b0;
            end else if (r_act) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (i_cmd.finish)
                r_out_valid <= 1'b1;
            else if (o_out_valid && !i_out_stall)
                r_out_valid <= 1'b0;
            if (i_cmd.finish) begin
                r_primed    <= 1'b1;
                r_held[0]   <= n_held0;
                r_held[1]   <= n_held1;
                r_lstep     <= r_in.step_time;
                r_lf        <= r_f;
                r_lv[0]     <= r_in.vel_x;
                r_lv[1]     <= r_in.vel_y;
                r_lv[2]     <= r_in.vel_z;
            end
        end
    end

    // payload datapath
    always_ff @(posedge i_clk) begin
        if (i_cmd.load)
            r_in <= i_in_data;
        if (i_cmd.start) begin
            r_op  <= i_cmd.op;
            r_sel <= i_cmd.sel;
        end
        if (i_cmd.finish)
            r_out <= '{accel_x: n_held0, accel_y: n_held1, updated: r_primed};
        if (i_cmd.load) begin
            r_f[0] <= sat_vw(98'(i_in_data.weight_x));
            r_f[1] <= sat_vw(98'(i_in_data.weight_y));
            r_f[2] <= sat_vw(98'(i_in_data.weight_z));
        end
        if (r_act) begin
            case (r_op)
                sfa_pkg::OP_CORDIC: begin
                    if (r_cnt == '0) begin
                        r_cx   <= sfa_pkg::GAIN_INV;
                        r_cy   <= '0;
                        r_cz   <= n_z0;
                        r_flip <= n_flip0;
                    end else if (r_cnt == CORDIC_END) begin
                        r_cos[sidx] <= cos_n[31:0];
                        r_sin[sidx] <= sin_n[31:0];
                    end else begin
                        r_cx <= n_cx;
                        r_cy <= n_cy;
                        r_cz <= n_cz;
                    end
                end
                sfa_pkg::OP_ROT: begin
                    if (r_cnt == '0) begin
                        r_p <= rot_bank ? r_a[rot_p] : r_f[rot_p];
                        r_c <= r_cos[rot_ax];
                        r_s <= rot_neg ? -r_sin[rot_ax] : r_sin[rot_ax];
                    end
                    if (r_cnt == CW'(1))
                        r_q <= rot_bank ? r_a[rot_q] : r_f[rot_q];
                    // issue product j, accumulate it in the next cycle
                    if (r_cnt >= CW'(2) && r_cnt <= CW'(9)) begin
                        r_prod       <= coef * chunk;
                        r_prod_hi    <= j[0];
                        r_prod_neg   <= !j[2] && j[1];
                        r_prod_first <= (j[1:0] == 2'd0);
                    end
                    if (r_cnt >= CW'(3) && r_cnt <= CW'(10))
                        r_acc <= r_prod_first ? term : r_acc + term;
                    if (r_cnt == CW'(7))
                        r_np <= sat_vw(rnd);
                    if (r_cnt == ROT_END) begin
                        if (rot_bank) begin
                            r_a[rot_p] <= r_np;
                            r_a[rot_q] <= sat_vw(rnd_q);
                        end else begin
                            r_f[rot_p] <= r_np;
                            r_f[rot_q] <= sat_vw(rnd_q);
                        end
                    end
                end
                sfa_pkg::OP_DIV_MASS, sfa_pkg::OP_DIV_VEL: begin
                    if (r_cnt == '0) begin
                        r_num <= mag98[NW-1:0];
                        r_neg <= num98[97];
                        r_rem <= '0;
                        r_dd  <= (r_op == sfa_pkg::OP_DIV_MASS) ? r_in.body_mass
                                                                : {16'd0, r_lstep};
                    end else if (r_cnt == DIV_END) begin
                        if (r_op == sfa_pkg::OP_DIV_MASS)
                            r_f[sidx] <= div_res;
                        else
                            r_a[sidx] <= div_res;
                    end else begin
                        r_rem <= ge ? 48'(trial - {1'b0, r_dd}) : trial[47:0];
                        r_num <= {r_num[NW-2:0], ge};
                    end
                end
                default: begin
                    // average the two force differences, dv held in r_a
                    for (int i = 0; i < 3; i++)
                        r_a[i] <= sat_vw((98'(r_f[i]) + 98'(r_lf[i])
                                          - (98'(r_a[i]) <<< 1)) >>> 1);
                end
            endcase
        end
    end

    assign o_sts.done     = done;
    assign o_sts.primed   = r_primed;
    assign o_sts.out_busy = r_out_valid && i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;

endmodule

FILE: rtl/core/specific_force_accelerometer_core.sv
// Top level of the specific force accelerometer: sequencer plus datapath.
// Depends on sfa_pkg, sfa_ctrl and sfa_datapath.
//
// One item at a time. Each beat runs three CORDIC evaluations, three
// inverse rotations on a shared 32x33 multiplier, and three bit-serial
// divisions of NW-bit numerators (NW = max(VALUE_WIDTH+16, 73)); an
// updating item adds three more divisions, one averaging step and three
// forward rotations. Most of an item's time goes to the divider, which
// yields one quotient bit per cycle. The result beat sits in an output
// register; a result still stalled there holds the finish of the next
// item, and a new item is taken in the cycle after a finish.
module specific_force_accelerometer_core #(
    parameter int VALUE_WIDTH  = 48,
    parameter int CORDIC_STEPS = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  sfa_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output sfa_pkg::t_out o_out_data
);

    sfa_pkg::t_cmd cmd;
    sfa_pkg::t_sts sts;

    sfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    sfa_datapath #(
        .VALUE_WIDTH  (VALUE_WIDTH),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // an accepted beat keeps the input side closed while it is worked on
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again right after an accept");

    // a result is never pushed over one that is still stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |-> !(o_out_valid && i_out_stall))
        else $error("result overwritten while stalled");

    // result valid only rises from a finishing step
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(cmd.finish))
        else $error("result valid without a finish");

    // a new datapath operation never starts in the cycle one completes
    a_start_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.done |-> !cmd.start)
        else $error("operation started on a done cycle");

endmodule

FILE: tb/tb_specific_force_accelerometer_core.sv
// Testbench for specific_force_accelerometer_core: random and directed steps
// checked beat by beat against an in-bench fixed-point predictor.
// Depends on sfa_pkg and the core RTL.
module tb_specific_force_accelerometer_core;

    localparam int VW = 48;
    localparam int STEPS = 24;
    localparam int WATCHDOG_LIMIT = 200000;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    sfa_pkg::t_in i_in_data;
    logic o_out_valid;
    logic i_out_stall;
    sfa_pkg::t_out o_out_data;

    specific_force_accelerometer_core #(.VALUE_WIDTH(VW), .CORDIC_STEPS(STEPS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data)
    );

    sfa_pkg::t_in step_queue[$];
    sfa_pkg::t_out accel_queue[$];
    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_recv = 0;
    bit hold_send = 0;
    bit stim_done = 0;
    int quiet_cycles = 0;

    // predictor state
    bit pr_primed;
    logic signed [VW-1:0] pr_last_f[3];
    logic signed [VW-1:0] pr_last_v[3];
    logic [31:0] pr_last_dt;
    logic signed [31:0] pr_held[2] = '{32'sd0, 32'sd0};

    localparam logic signed [63:0] ATAN_TAB[32] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h7FFF, 64'h3FFF, 64'h1FFF, 64'hFFF, 64'h7FF, 64'h3FF, 64'h1FF, 64'hFF,
        64'h7F, 64'h3F, 64'h1F, 64'hF, 64'h7, 64'h3, 64'h1, 64'h0, 64'h0};

    function automatic logic signed [63:0] clamp(input logic signed [191:0] v, input int n);
        logic signed [191:0] hi;
        logic signed [191:0] lo;
        hi = (192'sd1 <<< (n - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi[63:0];
        if (v < lo) return lo[63:0];
        return v[63:0];
    endfunction

    task automatic sin_cos(input logic signed [31:0] ang,
                           output logic signed [63:0] c, output logic signed [63:0] s);
        logic signed [63:0] z, x, y, dx, dy;
        bit flip;
        z = 64'(ang) * 2;
        x = 64'sd652032874;
        y = 0;
        flip = 0;
        if (z > 64'sd1686629713) begin
            z = z - 64'sd3373259426;
            flip = 1;
        end else if (z < -64'sd1686629713) begin
            z = z + 64'sd3373259426;
            flip = 1;
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> (i & 31);
            dy = x >>> (i & 31);
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_TAB[i & 31];
            end else begin
                x += dx; y -= dy; z += ATAN_TAB[i & 31];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic spin(inout logic signed [VW-1:0] p, inout logic signed [VW-1:0] q,
                        input logic signed [63:0] c, input logic signed [63:0] s);
        logic signed [191:0] np, nq;
        np = 192'(c) * 192'(p) - 192'(s) * 192'(q) + (192'sd1 <<< 29);
        nq = 192'(s) * 192'(p) + 192'(c) * 192'(q) + (192'sd1 <<< 29);
        p = VW'(clamp(np >>> 30, VW));
        q = VW'(clamp(nq >>> 30, VW));
    endtask

    function automatic logic signed [63:0] trunc_div(input logic signed [191:0] n,
                                                      input logic [63:0] d);
        logic [191:0] mag;
        logic [191:0] q;
        if (d == 0) return 64'sd0;
        mag = n < 0 ? 192'(-n) : 192'(n);
        q = mag / 192'(d);
        return clamp(n < 0 ? -$signed(q) : $signed(q), VW);
    endfunction

    task automatic predict_accel(input sfa_pkg::t_in it);
        logic signed [63:0] cx, sx, cy, sy, cz, sz;
        logic signed [VW-1:0] f[3];
        logic signed [VW-1:0] v[3];
        logic signed [VW-1:0] a[3];
        logic signed [63:0] dv;
        logic signed [191:0] sum;
        sfa_pkg::t_out r;
        sin_cos(it.angle_x, cx, sx);
        sin_cos(it.angle_y, cy, sy);
        sin_cos(it.angle_z, cz, sz);
        f[0] = it.weight_x; f[1] = it.weight_y; f[2] = it.weight_z;
        v[0] = it.vel_x; v[1] = it.vel_y; v[2] = it.vel_z;
        spin(f[0], f[1], cz, -sz);
        spin(f[2], f[0], cy, -sy);
        spin(f[1], f[2], cx, -sx);
        for (int i = 0; i < 3; i++)
            f[i] = VW'(trunc_div(192'(f[i]) <<< 16, 64'(it.body_mass)));
        if (!pr_primed) begin
            pr_primed = 1;
            r.updated = 0;
        end else begin
            for (int i = 0; i < 3; i++) begin
                dv = trunc_div((192'(v[i]) - 192'(pr_last_v[i])) <<< 24, 64'(pr_last_dt));
                sum = 192'(f[i]) + 192'(pr_last_f[i]) - 2 * 192'(dv);
                a[i] = VW'(clamp(sum >>> 1, VW));
            end
            spin(a[1], a[2], cx, sx);
            spin(a[2], a[0], cy, sy);
            spin(a[0], a[1], cz, sz);
            pr_held[0] = 32'(clamp(-192'(a[2]), 32));
            pr_held[1] = 32'(clamp(-192'(a[1]), 32));
            r.updated = 1;
        end
        for (int i = 0; i < 3; i++) begin
            pr_last_f[i] = f[i];
            pr_last_v[i] = v[i];
        end
        pr_last_dt = it.step_time;
        r.accel_x = pr_held[0];
        r.accel_y = pr_held[1];
        accel_queue.push_back(r);
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("error: %s got %h want %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic logic [47:0] rnd48();
        return {16'($urandom), $urandom};
    endfunction

    function automatic logic [31:0] rnd_angle();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'sd1686629713 : -32'sd1686629713;
            default: return 32'($signed($urandom_range(0, 1686629713 * 2)) - 1686629713);
        endcase
    endfunction

    function automatic logic [47:0] rnd_vec();
        case ($urandom_range(0, 4))
            0: return rnd48();
            1: return 48'($signed(32'($urandom)) >>> $urandom_range(0, 20));
            default: return 48'($signed(32'($urandom_range(0, 2000000))) - 1000000) <<< 4;
        endcase
    endfunction

    function automatic sfa_pkg::t_in rnd_step();
        sfa_pkg::t_in it;
        it.angle_x = rnd_angle();
        it.angle_y = rnd_angle();
        it.angle_z = rnd_angle();
        it.weight_x = rnd_vec();
        it.weight_y = rnd_vec();
        it.weight_z = rnd_vec();
        case ($urandom_range(0, 5))
            0: it.body_mass = rnd48();
            1: it.body_mass = 48'($urandom_range(0, 3));
            default: it.body_mass = 48'($urandom_range(1, 1 << 24)) << $urandom_range(0, 12);
        endcase
        it.vel_x = rnd_vec();
        it.vel_y = rnd_vec();
        it.vel_z = rnd_vec();
        case ($urandom_range(0, 4))
            0: it.step_time = $urandom;
            1: it.step_time = $urandom_range(0, 1) ? 32'd0 : 32'd1;
            default: it.step_time = $urandom_range(1 << 16, 1 << 25);
        endcase
        return it;
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 0;
            i_in_data <= '0;
        end else if (!(i_in_valid && o_in_stall)) begin
            if (step_queue.size() > 0 && !hold_send &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                i_in_valid <= 1;
                i_in_data <= step_queue.pop_front();
            end else begin
                i_in_valid <= 0;
            end
        end
    end

    // receiver stall
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_out_stall <= 0;
        else
            i_out_stall <= hold_recv || ($urandom_range(0, 99) < recv_stall_pct);
    end

    // monitor: predict on accepted input beats, check output beats
    always @(posedge i_clk) begin
        sfa_pkg::t_out want;
        bit seen;
        if (i_rst_n) begin
            seen = 0;
            if (i_in_valid && !o_in_stall) begin
                predict_accel(i_in_data);
                seen = 1;
            end
            if (o_out_valid && !i_out_stall) begin
                seen = 1;
                if (accel_queue.size() == 0) begin
                    report("unexpected beat", 64'(o_out_data), 0);
                end else begin
                    want = accel_queue.pop_front();
                    if (o_out_data.accel_x !== want.accel_x)
                        report("accel_x", 64'(o_out_data.accel_x), 64'(want.accel_x));
                    if (o_out_data.accel_y !== want.accel_y)
                        report("accel_y", 64'(o_out_data.accel_y), 64'(want.accel_y));
                    if (o_out_data.updated !== want.updated)
                        report("updated", 64'(o_out_data.updated), 64'(want.updated));
                end
            end
            if (seen)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (step_queue.size() > 0 || i_in_valid || accel_queue.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        sfa_pkg::t_in it;
        i_rst_n = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: priming step, extremes, zero mass, zero step time, zero weight
        it = '0;
        it.body_mass = 48'h1_0000;
        it.step_time = 32'h0100_0000;
        step_queue.push_back(it);
        it.angle_x = 32'h7FFF_FFFF; it.angle_y = 32'h8000_0000; it.angle_z = 32'sd1686629713;
        it.weight_x = 48'h7FFF_FFFF_FFFF; it.weight_y = 48'h8000_0000_0000;
        it.weight_z = 48'h7FFF_FFFF_FFFF; it.body_mass = 48'd1;
        it.vel_x = 48'h8000_0000_0000; it.vel_y = 48'h7FFF_FFFF_FFFF; it.vel_z = 48'd0;
        it.step_time = 32'hFFFF_FFFF;
        step_queue.push_back(it);
        it.body_mass = 48'hFFFF_FFFF_FFFF;
        it.angle_x = -32'sd1686629713; it.angle_y = 32'h4000_0000; it.angle_z = 32'h8000_0001;
        it.vel_x = 48'h7FFF_FFFF_FFFF; it.vel_y = 48'h8000_0000_0000; it.step_time = 32'd1;
        step_queue.push_back(it);
        it.body_mass = 48'd0; it.step_time = 32'd0;
        step_queue.push_back(it);
        it = rnd_step();
        step_queue.push_back(it);
        it.weight_x = 0; it.weight_y = 0; it.weight_z = 0; it.step_time = 32'd1;
        step_queue.push_back(it);
        it.vel_x = ~it.vel_x; it.vel_y = 48'h0000_0001_0000; it.body_mass = 48'd3;
        step_queue.push_back(it);
        it.angle_x = 32'hC000_0000; it.angle_y = 32'hFFFF_FFFF; it.angle_z = 32'h0;
        step_queue.push_back(it);
        for (int i = 0; i < 8; i++)
            step_queue.push_back(rnd_step());
        wait_drained();

        // random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 23 : 59) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 23 : 59) : 0;
            for (int i = 0; i < 130; i++)
                step_queue.push_back(rnd_step());
            if (ph == 2) begin
                // long receiver hold-off while the sender keeps offering
                hold_recv = 1;
                repeat (3000) @(posedge i_clk);
                hold_recv = 0;
            end
            wait_drained();
            // sender pause with nothing outstanding
            hold_send = 1;
            repeat ($urandom_range(5, 50)) @(posedge i_clk);
            hold_send = 0;
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_drained();
        repeat (1500) @(posedge i_clk);
        if (mismatches == 0 && accel_queue.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
